### rtl/esfc_pkg.sv
package esfc_pkg;

  localparam int ButtonW = 5;
  localparam int TargetW = 3;
  localparam int PhaseW = 3;
  localparam int PosW = 12;
  localparam int CoilW = 4;
  localparam int GoalW = 17;
  localparam int PosLimit = 4095;
  localparam int InDataW = 8;
  localparam int OutDataW = 24;

  localparam int DefNumFloors = 5;
  localparam int DefCyclesPerFloor = 720;

  localparam logic [PhaseW-1:0] PhaseLast = 3'd7;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    logic [TargetW-1:0] target;
    dir_e               dir;
    logic [PhaseW-1:0]  phase;
    logic [PosW-1:0]    pos;
    logic               near;
  } state_t;

  typedef struct packed {
    logic [CoilW-1:0]   coil;
    dir_e               dir;
    logic               at_floor;
    logic               near;
    logic [TargetW-1:0] goal;
    logic [PosW-1:0]    pos;
  } result_t;

  function automatic logic [CoilW-1:0] coil_pattern(logic [PhaseW-1:0] phase);
    logic [CoilW-1:0] pat;
    case (phase)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

### rtl/esfc_step.sv
module esfc_step #(
  parameter int NUM_FLOORS = esfc_pkg::DefNumFloors,
  parameter int CYCLES_PER_FLOOR = esfc_pkg::DefCyclesPerFloor
) (
  input  esfc_pkg::state_t                    state_i,
  input  logic [esfc_pkg::ButtonW-1:0]        presses_i,
  output esfc_pkg::state_t                    state_o,
  output esfc_pkg::result_t                   result_o
);

  localparam int TopRaw = (NUM_FLOORS - 1) * CYCLES_PER_FLOOR;
  localparam int TopPos = (TopRaw > esfc_pkg::PosLimit) ? esfc_pkg::PosLimit : TopRaw;
  localparam logic [esfc_pkg::PosW-1:0] TopPosC = esfc_pkg::PosW'(TopPos);
  localparam logic [esfc_pkg::GoalW-1:0] CpfC = esfc_pkg::GoalW'(CYCLES_PER_FLOOR);

  logic [esfc_pkg::GoalW-1:0]   goal_pos;
  logic [esfc_pkg::GoalW-1:0]   pos_ext;
  logic                         arrived;
  logic                         found;
  logic [esfc_pkg::TargetW-1:0] sel;
  esfc_pkg::state_t             nxt;

  assign goal_pos = esfc_pkg::GoalW'(state_i.target) * CpfC;
  assign pos_ext  = esfc_pkg::GoalW'(state_i.pos);

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < esfc_pkg::ButtonW; i++) begin
      if (!found && presses_i[i] && (i < NUM_FLOORS)) begin
        found = 1'b1;
        sel   = esfc_pkg::TargetW'(i);
      end
    end
  end

  always_comb begin
    nxt     = state_i;
    arrived = 1'b0;

    if (pos_ext == goal_pos) begin
      nxt.dir = esfc_pkg::DIR_IDLE;
      arrived = 1'b1;
    end else if ((pos_ext + 1'b1 == goal_pos) || (pos_ext == goal_pos + 1'b1)) begin
      nxt.near = 1'b1;
    end

    if (found) begin
      if (sel == state_i.target) begin
        nxt.dir = esfc_pkg::DIR_IDLE;
      end else begin
        nxt.dir    = (sel > state_i.target) ? esfc_pkg::DIR_UP : esfc_pkg::DIR_DOWN;
        nxt.target = sel;
      end
    end

    case (nxt.dir)
      esfc_pkg::DIR_UP: begin
        if (state_i.phase == esfc_pkg::PhaseLast) begin
          nxt.phase = '0;
          if (state_i.pos < TopPosC) begin
            nxt.pos = state_i.pos + 1'b1;
          end
        end else begin
          nxt.phase = state_i.phase + 1'b1;
        end
      end
      esfc_pkg::DIR_DOWN: begin
        if (state_i.phase == '0) begin
          nxt.phase = esfc_pkg::PhaseLast;
          if (state_i.pos != '0) begin
            nxt.pos = state_i.pos - 1'b1;
          end
        end else begin
          nxt.phase = state_i.phase - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign state_o = nxt;

  always_comb begin
    result_o.coil     = esfc_pkg::coil_pattern(state_i.phase);
    result_o.dir      = nxt.dir;
    result_o.at_floor = arrived;
    result_o.near     = nxt.near;
    result_o.goal     = nxt.target;
    result_o.pos      = nxt.pos;
  end

endmodule

### rtl/esfc_skid.sv
module esfc_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  esfc_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output esfc_pkg::result_t data_o
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  esfc_pkg::result_t main_q, main_d;
  esfc_pkg::result_t skid_q, skid_d;
  logic              pop;
  logic              main_free;

  assign pop       = main_valid_q && pop_ready_i;
  assign main_free = !main_valid_q || pop;

  always_comb begin
    main_valid_d = main_valid_q;
    main_d       = main_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

endmodule

### rtl/elevator_stepper_floor_controller.sv
// Elevator stepper floor controller. Every input word is one motor tick carrying the floor
// button presses of that tick, and every tick yields exactly one output word with the coil
// pattern driven, the new direction, the arrival and sticky near flags, the target floor and
// the car position in full phase cycles. A tick is taken in every clock cycle while the
// output buffer has room: arrival check, button decode and phase advance are one
// combinational pass on the state registers, and the result goes into a two-entry output
// buffer, so the input side keeps accepting while one result waits.
module elevator_stepper_floor_controller #(
  parameter int NUM_FLOORS = esfc_pkg::DefNumFloors,
  parameter int CYCLES_PER_FLOOR = esfc_pkg::DefCyclesPerFloor
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // Fields from bit 0: button_presses[4:0], zero fill.
  input  logic [esfc_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // Fields from bit 0: coil_drive[3:0], move_dir[5:4], at_floor[6], near_flag[7],
  // goal_floor[10:8], car_position[22:11], zero fill.
  output logic [esfc_pkg::OutDataW-1:0] m_axis_tdata_o
);

  esfc_pkg::state_t  state_q, state_d;
  esfc_pkg::result_t step_res;
  esfc_pkg::result_t out_res;
  logic              accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  esfc_step #(
    .NUM_FLOORS       (NUM_FLOORS),
    .CYCLES_PER_FLOOR (CYCLES_PER_FLOOR)
  ) u_step (
    .state_i   (state_q),
    .presses_i (s_axis_tdata_i[esfc_pkg::ButtonW-1:0]),
    .state_o   (state_d),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{target: '0, dir: esfc_pkg::DIR_IDLE, phase: '0, pos: '0, near: 1'b0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  esfc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (step_res),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {1'b0, out_res.pos, out_res.goal, out_res.near, out_res.at_floor,
                           out_res.dir, out_res.coil};

  near_sticky_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.near |=> state_q.near)
    else $error("near flag cleared outside reset");

  idle_holds_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (state_d.dir == esfc_pkg::DIR_IDLE)) |=>
      ($stable(state_q.phase) && $stable(state_q.pos)))
    else $error("phase or position moved on an idle tick");

  no_stall_empty_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled while no output word is pending");

endmodule
